// ===== src/stable_priority_queue_defines.svh =====
// Assertion macros for the checker file of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
package spq_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_POPPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  entry_priority;
        logic [15:0] entry_tag;
    } t_spq_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_priority;
        logic [15:0] out_tag;
        logic [4:0]  occupancy;
    } t_spq_rsp;

    typedef struct packed {
        logic [3:0]  prio;
        logic [15:0] tag;
    } t_spq_entry;

    // Broadcast from the queue control to every cell.
    typedef struct packed {
        logic       insert;
        logic       pop;
        t_spq_entry entry;
    } t_spq_cell_ctrl;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell (
    input  logic                    i_clk,
    input  spq_pkg::t_spq_cell_ctrl i_ctrl,
    input  logic                    i_filled,
    input  logic                    i_left_keep,
    input  spq_pkg::t_spq_entry     i_left_entry,
    input  spq_pkg::t_spq_entry     i_right_entry,
    output logic                    o_keep,
    output spq_pkg::t_spq_entry     o_entry
);

    spq_pkg::t_spq_entry r_entry;
    spq_pkg::t_spq_entry n_entry;

    // An entry stays in place on insert when its priority does not exceed the new one,
    // which keeps entries of equal priority in arrival order.
    assign o_keep  = i_filled && (r_entry.prio <= i_ctrl.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.insert) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctrl.entry;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== src/stable_priority_queue.sv =====
// Channel   | Ports                             | Transfer when
// ----------+-----------------------------------+------------------------------
// request   | start, busy, i_req                | start high and busy low
// result    | o_result_valid, o_result          | o_result_valid high (1 cycle)
//
// One request can be taken in every cycle that busy is low; its result appears on the next cycle.
// Every cell of the shift chain compares its priority with the new entry in parallel,
// so every cell takes its new entry in the same cycle as an insert or a pop is accepted.
// busy is high only while reset is asserted; reset empties the queue.
// The receiver cannot stall: each result is shown for exactly one cycle.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  spq_pkg::t_spq_req i_req,
    output logic              busy,
    output logic              o_result_valid,
    output spq_pkg::t_spq_rsp o_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = CW + 5;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_valid;
    spq_pkg::t_spq_rsp        r_result;
    spq_pkg::t_spq_rsp        n_result;
    spq_pkg::t_spq_cell_ctrl  w_ctrl;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic [EW-1:0]            w_occ_ext;
    logic [QUEUE_DEPTH-1:0]   w_filled;
    logic [QUEUE_DEPTH-1:0]   w_keep;
    spq_pkg::t_spq_entry      w_entry [QUEUE_DEPTH];

    assign busy     = ~i_rst_n;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.insert     = w_accept && (i_req.req_type == spq_pkg::REQ_INSERT) && !w_full;
    assign w_ctrl.pop        = w_accept && (i_req.req_type == spq_pkg::REQ_POP) && !w_empty;
    assign w_ctrl.entry.prio = i_req.entry_priority;
    assign w_ctrl.entry.tag  = i_req.entry_tag;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign w_filled[g] = (r_count > CW'(g));

        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_filled      (w_filled[g]),
                .i_left_keep   (1'b1),
                .i_left_entry  (w_ctrl.entry),
                .i_right_entry (w_entry[g+1]),
                .o_keep        (w_keep[g]),
                .o_entry       (w_entry[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_filled      (w_filled[g]),
                .i_left_keep   (w_keep[g-1]),
                .i_left_entry  (w_entry[g-1]),
                .i_right_entry (w_entry[g]),
                .o_keep        (w_keep[g]),
                .o_entry       (w_entry[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_filled      (w_filled[g]),
                .i_left_keep   (w_keep[g-1]),
                .i_left_entry  (w_entry[g-1]),
                .i_right_entry (w_entry[g+1]),
                .o_keep        (w_keep[g]),
                .o_entry       (w_entry[g])
            );
        end
    end

    always_comb begin
        n_count               = r_count;
        n_result.status       = spq_pkg::ST_INSERTED;
        n_result.out_priority = '0;
        n_result.out_tag      = '0;
        priority if (w_ctrl.insert) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.pop) begin
            n_count               = r_count - CW'(1);
            n_result.status       = spq_pkg::ST_POPPED;
            n_result.out_priority = w_entry[0].prio;
            n_result.out_tag      = w_entry[0].tag;
        end else if (i_req.req_type == spq_pkg::REQ_INSERT) begin
            n_result.status = spq_pkg::ST_FULL;
        end else begin
            n_result.status = spq_pkg::ST_EMPTY;
        end
        // Occupancy is reported modulo 32.
        w_occ_ext          = EW'(n_count);
        n_result.occupancy = w_occ_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule

// ===== src/spq_checker.sv =====
`include "stable_priority_queue_defines.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input spq_pkg::t_spq_rsp o_result
);

    localparam logic [4:0] FULL_OCC = 5'(QUEUE_DEPTH);

    // Every accepted transfer yields exactly one result on the following cycle.
    `SPQ_ASSERT(a_result_follows, i_clk, i_rst_n, (start && !busy) |=> o_result_valid, "result missing after request")
    `SPQ_ASSERT(a_no_spurious, i_clk, i_rst_n, !(start && !busy) |=> !o_result_valid, "result without request")

    // Only a pop carries entry data.
    `SPQ_ASSERT(a_data_on_pop, i_clk, i_rst_n, (o_result_valid && (o_result.status != spq_pkg::ST_POPPED)) |-> (o_result.out_priority == '0 && o_result.out_tag == '0), "entry data outside a pop")

    // A refused insert sees a full queue, an empty pop an empty one.
    `SPQ_ASSERT(a_full_occ, i_clk, i_rst_n, (o_result_valid && (o_result.status == spq_pkg::ST_FULL)) |-> (o_result.occupancy == FULL_OCC), "full status with queue not full")
    `SPQ_ASSERT(a_empty_occ, i_clk, i_rst_n, (o_result_valid && (o_result.status == spq_pkg::ST_EMPTY)) |-> (o_result.occupancy == '0), "empty status with entries held")

endmodule

bind stable_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

// ===== tb/stable_priority_queue_tb.sv =====
`timescale 1ns / 100ps

module stable_priority_queue_tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int PHASE_ITEMS = 256;
    localparam int MAX_GAP     = 12;

    typedef struct {
        spq_pkg::t_spq_req req;
        bit                fixed;
        spq_pkg::t_spq_rsp rsp;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    spq_pkg::t_spq_req i_req;
    logic              busy;
    logic              o_result_valid;
    spq_pkg::t_spq_rsp o_result;

    // Shadow copy of the queue contents, kept sorted like the block's cells.
    spq_pkg::t_spq_entry model_slots[QUEUE_DEPTH];
    int                  model_fill;

    spq_pkg::t_spq_rsp expected_results[$];
    int                mismatch_count;

    // Set by the driver with each request; lets a table row pin its result.
    bit                next_fixed;
    spq_pkg::t_spq_rsp next_fixed_rsp;

    t_dir_row dir_rows[23];
    int       idle_by_phase[4];

    stable_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req          (i_req),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic spq_pkg::t_spq_rsp queue_apply(input spq_pkg::t_spq_req r);
        spq_pkg::t_spq_rsp rsp;
        int                pos;
        rsp = '0;
        if (r.req_type == spq_pkg::REQ_INSERT) begin
            if (model_fill >= QUEUE_DEPTH) begin
                rsp.status = spq_pkg::ST_FULL;
            end else begin
                // Equal priorities stay in arrival order: skip past them.
                pos = 0;
                while (pos < model_fill && model_slots[pos].prio <= r.entry_priority) pos++;
                for (int i = model_fill; i > pos; i--) model_slots[i] = model_slots[i - 1];
                model_slots[pos].prio = r.entry_priority;
                model_slots[pos].tag  = r.entry_tag;
                model_fill++;
                rsp.status = spq_pkg::ST_INSERTED;
            end
        end else if (model_fill == 0) begin
            rsp.status = spq_pkg::ST_EMPTY;
        end else begin
            rsp.status       = spq_pkg::ST_POPPED;
            rsp.out_priority = model_slots[0].prio;
            rsp.out_tag      = model_slots[0].tag;
            for (int i = 1; i < model_fill; i++) model_slots[i - 1] = model_slots[i];
            model_fill--;
        end
        rsp.occupancy = 5'(model_fill);
        return rsp;
    endfunction

    function automatic t_dir_row mk_row(input logic req_type, input logic [3:0] prio,
                                        input logic [15:0] tag, input bit fixed,
                                        input logic [1:0] st, input logic [4:0] occ);
        t_dir_row row;
        row.req.req_type       = req_type;
        row.req.entry_priority = prio;
        row.req.entry_tag      = tag;
        row.fixed              = fixed;
        row.rsp                = '0;
        row.rsp.status         = st;
        row.rsp.occupancy      = occ;
        return row;
    endfunction

    // Accept and predict first, then check the result of the previous transfer.
    always @(posedge i_clk) begin
        spq_pkg::t_spq_rsp want;
        spq_pkg::t_spq_rsp got;
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            want = queue_apply(i_req);
            if (next_fixed) want = next_fixed_rsp;
            expected_results.push_back(want);
        end
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            got = o_result;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              got.status, want.status));
                if (got.out_priority !== want.out_priority)
                    report_mismatch($sformatf("out_priority got %0d want %0d",
                                              got.out_priority, want.out_priority));
                if (got.out_tag !== want.out_tag)
                    report_mismatch($sformatf("out_tag got %h want %h",
                                              got.out_tag, want.out_tag));
                if (got.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              got.occupancy, want.occupancy));
            end
        end
    end

    task automatic send_request(input spq_pkg::t_spq_req req, input bit fixed,
                                input spq_pkg::t_spq_rsp fixed_rsp, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_req          <= req;
        next_fixed     = fixed;
        next_fixed_rsp = fixed_rsp;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic drain_results();
        int waited;
        @(negedge i_clk);
        start  <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    initial begin
        spq_pkg::t_spq_req req;
        int                ins_pct;
        bit                narrow;

        mismatch_count = 0;
        model_fill     = 0;
        next_fixed     = 1'b0;
        next_fixed_rsp = '0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        idle_by_phase  = '{0, 67, 0, 8};

        // Empty pop, fill to the brim with ties and extremes, refused inserts.
        dir_rows = '{
            mk_row(spq_pkg::REQ_POP,    4'd0,  16'h0000, 1'b1, spq_pkg::ST_EMPTY,    5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd15, 16'hFFFF, 1'b1, spq_pkg::ST_INSERTED, 5'd1),
            mk_row(spq_pkg::REQ_INSERT, 4'd0,  16'h0000, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd15, 16'h0001, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd7,  16'hAAAA, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd0,  16'h5555, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd8,  16'h1234, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd3,  16'h8000, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd3,  16'h0003, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd12, 16'hC0DE, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd1,  16'h7FFF, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd15, 16'h0F0F, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd0,  16'hF0F0, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd9,  16'h0999, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd4,  16'h4444, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd14, 16'hEEEE, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd6,  16'h6666, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd0,  16'hFFFF, 1'b1, spq_pkg::ST_FULL,     5'd16),
            mk_row(spq_pkg::REQ_POP,    4'd0,  16'h0000, 1'b0, spq_pkg::ST_POPPED,   5'd0),
            mk_row(spq_pkg::REQ_POP,    4'd15, 16'hFFFF, 1'b0, spq_pkg::ST_POPPED,   5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd15, 16'hFFFF, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd0,  16'h0000, 1'b0, spq_pkg::ST_INSERTED, 5'd0),
            mk_row(spq_pkg::REQ_INSERT, 4'd15, 16'hFFFF, 1'b1, spq_pkg::ST_FULL,     5'd16)
        };

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].fixed,
                                           dir_rows[i].rsp, 0);

        // Phases of random traffic; each one ends by letting the queue of
        // expected results run dry before the next begins.
        for (int phase = 0; phase < 4; phase++) begin
            ins_pct = 50;
            narrow  = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Bursts that lean toward insert or pop walk the queue
                // between empty and full; a narrow range of priorities makes ties.
                if (n % 32 == 0) begin
                    case ($urandom_range(2))
                        0:       ins_pct = 15;
                        1:       ins_pct = 50;
                        default: ins_pct = 85;
                    endcase
                    narrow = 1'($urandom_range(1));
                end
                req.req_type       = ($urandom_range(99) < ins_pct) ? spq_pkg::REQ_INSERT
                                                                     : spq_pkg::REQ_POP;
                req.entry_priority = narrow ? 4'($urandom_range(2)) : 4'($urandom_range(15));
                req.entry_tag      = 16'($urandom_range(16'hFFFF));
                send_request(req, 1'b0, '0, idle_by_phase[phase]);
            end
            drain_results();
        end

        repeat (5) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
